// ===== hdl/stabilizer_startup_sequencer_assert.svh =====
// Assertion macros for the stabilizer startup sequencer checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef STABILIZER_STARTUP_SEQUENCER_ASSERT_SVH
`define STABILIZER_STARTUP_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sss_pkg.sv =====
// Shared types, constants and helpers for the stabilizer startup sequencer.
// No dependencies; used by every module of the block.
`default_nettype none

package sss_pkg;

  localparam int unsigned TimeW    = 32;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned PhaseW   = 3;

  typedef logic [TimeW-1:0] time_t;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    RegInitRetry   = 4'd0,
    RegBootDelay   = 4'd1,
    RegStage       = 4'd2,
    RegResend      = 4'd3,
    RegSettle      = 4'd4,
    RegSamplePer   = 4'd5,
    RegControlPer  = 4'd6,
    RegFbTimeout   = 4'd7
  } cfg_idx_e;

  // Reported phase codes
  localparam logic [PhaseW-1:0] PhaseCodeInit   = 3'd0;
  localparam logic [PhaseW-1:0] PhaseCodeBoot   = 3'd1;
  localparam logic [PhaseW-1:0] PhaseCodeEnable = 3'd2;
  localparam logic [PhaseW-1:0] PhaseCodeSpeed  = 3'd3;
  localparam logic [PhaseW-1:0] PhaseCodeLock   = 3'd4;
  localparam logic [PhaseW-1:0] PhaseCodeRun    = 3'd5;

  typedef enum logic [5:0] {
    PhInit   = 6'b000001,
    PhBoot   = 6'b000010,
    PhEnable = 6'b000100,
    PhSpeed  = 6'b001000,
    PhLock   = 6'b010000,
    PhRun    = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [15:0] init_retry_ms;
    logic [15:0] boot_delay_ms;
    logic [15:0] stage_ms;
    logic [15:0] resend_ms;
    logic [15:0] settle_ms;
    logic [7:0]  sample_period_ms;
    logic [7:0]  control_period_ms;
    logic [15:0] feedback_timeout_ms;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    init_retry_ms:       16'd200,
    boot_delay_ms:       16'd2000,
    stage_ms:            16'd500,
    resend_ms:           16'd100,
    settle_ms:           16'd200,
    sample_period_ms:    8'd2,
    control_period_ms:   8'd5,
    feedback_timeout_ms: 16'd50
  };

  typedef struct packed {
    logic sensor_ready;
    logic encoder_frame;
  } in_t;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic              init_attempt;
    logic              send_enable;
    logic              send_speed_mode;
    logic              sample_strobe;
    logic              lock_reference;
    logic              control_strobe;
    logic              pitch_base_lock;
    logic              pitch_closed;
  } out_t;

  // Wrapping difference of two stamps
  function automatic time_t elapsed(time_t now, time_t stamp);
    return now - stamp;
  endfunction

  function automatic logic [PhaseW-1:0] phase_code(phase_e ph);
    logic [PhaseW-1:0] code;
    case (ph)
      PhInit:   code = PhaseCodeInit;
      PhBoot:   code = PhaseCodeBoot;
      PhEnable: code = PhaseCodeEnable;
      PhSpeed:  code = PhaseCodeSpeed;
      PhLock:   code = PhaseCodeLock;
      PhRun:    code = PhaseCodeRun;
      default:  code = PhaseCodeInit;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sss_cfg.sv =====
// Configuration register file of the startup sequencer.
// Depends on sss_pkg for the register layout and reset values.
`default_nettype none

module sss_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [sss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sss_pkg::CfgDataW-1:0] cfg_data_i,
  output sss_pkg::cfg_t                     cfg_o
);
  import sss_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        RegInitRetry:  cfg_d.init_retry_ms       = cfg_data_i;
        RegBootDelay:  cfg_d.boot_delay_ms       = cfg_data_i;
        RegStage:      cfg_d.stage_ms            = cfg_data_i;
        RegResend:     cfg_d.resend_ms           = cfg_data_i;
        RegSettle:     cfg_d.settle_ms           = cfg_data_i;
        RegSamplePer:  cfg_d.sample_period_ms    = cfg_data_i[7:0];
        RegControlPer: cfg_d.control_period_ms   = cfg_data_i[7:0];
        RegFbTimeout:  cfg_d.feedback_timeout_ms = cfg_data_i;
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/sss_core.sv =====
// Phase sequencer and strobe logic: timing state plus the per-item decision.
// Depends on sss_pkg; state advances only on cycles with step_i high.
`default_nettype none

module sss_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          step_i,
  input  wire sss_pkg::in_t  item_i,
  input  wire sss_pkg::cfg_t cfg_i,
  output sss_pkg::out_t      res_o
);
  import sss_pkg::*;

  phase_e phase_q, phase_d;
  time_t  now_q, phase_start_q, phase_start_d, aux_q, aux_d;
  time_t  ctl_stamp_q, ctl_stamp_d, fb_stamp_q, fb_stamp_d;
  logic   fb_seen_q, fb_seen_d, base_q, base_d;
  logic   fresh;
  out_t   res;

  always_comb begin
    phase_d       = phase_q;
    phase_start_d = phase_start_q;
    aux_d         = aux_q;
    ctl_stamp_d   = ctl_stamp_q;
    fb_stamp_d    = fb_stamp_q;
    fb_seen_d     = fb_seen_q;
    base_d        = base_q;
    res           = '0;
    res.phase     = phase_code(phase_q);

    // frame stamps feedback before the phase logic looks at it
    if (item_i.encoder_frame) begin
      fb_stamp_d = now_q;
      fb_seen_d  = 1'b1;
    end
    fresh = fb_seen_d &&
            (elapsed(now_q, fb_stamp_d) < time_t'(cfg_i.feedback_timeout_ms));

    case (phase_q)
      PhInit: begin
        if (elapsed(now_q, phase_start_q) >= time_t'(cfg_i.init_retry_ms)) begin
          res.init_attempt = 1'b1;
          if (item_i.sensor_ready) begin
            phase_d = PhBoot;
            aux_d   = '0;
          end
          phase_start_d = now_q;
        end
      end
      PhBoot: begin
        if (elapsed(now_q, phase_start_q) >= time_t'(cfg_i.boot_delay_ms)) begin
          phase_d       = PhEnable;
          phase_start_d = now_q;
          aux_d         = now_q;
        end
      end
      PhEnable: begin
        if (elapsed(now_q, aux_q) >= time_t'(cfg_i.resend_ms)) begin
          aux_d           = now_q;
          res.send_enable = 1'b1;
        end
        if (elapsed(now_q, phase_start_q) >= time_t'(cfg_i.stage_ms)) begin
          phase_d       = PhSpeed;
          phase_start_d = now_q;
          aux_d         = now_q;
        end
      end
      PhSpeed: begin
        if (elapsed(now_q, aux_q) >= time_t'(cfg_i.resend_ms)) begin
          aux_d               = now_q;
          res.send_speed_mode = 1'b1;
        end
        if (elapsed(now_q, phase_start_q) >= time_t'(cfg_i.stage_ms)) begin
          phase_d       = PhLock;
          phase_start_d = now_q;
          aux_d         = '0;
        end
      end
      PhLock: begin
        if (elapsed(now_q, aux_q) >= time_t'(cfg_i.sample_period_ms)) begin
          aux_d             = now_q;
          res.sample_strobe = 1'b1;
        end
        // strictly greater: lock tick comes one ms after settle elapses
        if (elapsed(now_q, phase_start_q) > time_t'(cfg_i.settle_ms)) begin
          res.lock_reference = 1'b1;
          base_d             = 1'b0;
          ctl_stamp_d        = now_q;
          phase_d            = PhRun;
        end
      end
      PhRun: begin
        if (elapsed(now_q, aux_q) >= time_t'(cfg_i.sample_period_ms)) begin
          aux_d             = now_q;
          res.sample_strobe = 1'b1;
        end
        if (elapsed(now_q, ctl_stamp_q) >= time_t'(cfg_i.control_period_ms)) begin
          ctl_stamp_d        = now_q;
          res.control_strobe = 1'b1;
          if (fresh && !base_q) begin
            base_d              = 1'b1;
            res.pitch_base_lock = 1'b1;
          end
          res.pitch_closed = base_d && fresh;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhInit;
      now_q         <= '0;
      phase_start_q <= '0;
      aux_q         <= '0;
      ctl_stamp_q   <= '0;
      fb_stamp_q    <= '0;
      fb_seen_q     <= 1'b0;
      base_q        <= 1'b0;
    end else if (step_i) begin
      phase_q       <= phase_d;
      now_q         <= now_q + time_t'(1);
      phase_start_q <= phase_start_d;
      aux_q         <= aux_d;
      ctl_stamp_q   <= ctl_stamp_d;
      fb_stamp_q    <= fb_stamp_d;
      fb_seen_q     <= fb_seen_d;
      base_q        <= base_d;
    end
  end

  assign res_o = res;

endmodule

`default_nettype wire

// ===== hdl/stabilizer_startup_sequencer.sv =====
// Stabilizer startup sequencer, top level (uses sss_pkg, sss_cfg, sss_core). Each item is
// one millisecond tick; the block walks sensor init, boot wait, enable, speed mode, lock
// and run, and returns one strobe word per item. An accepted item sits in an input
// register; once the result register is free or draining, the phase logic evaluates it
// against the timing state and loads the result register, so the result is registered,
// and one item is taken every cycle while results drain. While a result waits, one more
// item can still be taken into the input register; after that a result stall holds the
// input in the same cycle. Configuration writes take effect from the next processed item.
`default_nettype none

module stabilizer_startup_sequencer (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire sss_pkg::in_t                 in_data_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output sss_pkg::out_t                     out_data_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [sss_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sss_pkg::CfgDataW-1:0] cfg_data_i
);
  import sss_pkg::*;

  cfg_t cfg;
  in_t  in_q;
  out_t res, out_q;
  logic in_valid_q, in_valid_d, out_valid_q, out_valid_d;
  logic step, in_take;

  // process the held item when the result register is free or draining
  assign step    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_take = in_valid_i && !in_stall_o;

  assign in_stall_o  = in_valid_q && !step;
  assign in_valid_d  = in_take || (in_valid_q && !step);
  assign out_valid_d = step || (out_valid_q && out_stall_i);

  sss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sss_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
    if (step) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== hdl/sss_checker.sv =====
// Port-level checks for the stabilizer startup sequencer, bound to the top level.
// Depends on sss_pkg and the assertion macro header.
`default_nettype none
`include "stabilizer_startup_sequencer_assert.svh"

module sss_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire sss_pkg::out_t out_data_o
);
  import sss_pkg::*;

  `SSS_ASSERT_NEXT(a_out_hold,
    out_valid_o && out_stall_i,
    out_valid_o && $stable(out_data_o),
    "stalled result item changed")
  `SSS_ASSERT_NOW(a_closed_needs_ctl,
    out_valid_o && out_data_o.pitch_closed,
    out_data_o.control_strobe,
    "pitch_closed without control strobe")
  `SSS_ASSERT_NOW(a_base_lock_closed,
    out_valid_o && out_data_o.pitch_base_lock,
    out_data_o.pitch_closed && out_data_o.phase == PhaseCodeRun,
    "base lock outside a closed run tick")
  `SSS_ASSERT_NOW(a_lock_in_lock,
    out_valid_o && out_data_o.lock_reference,
    out_data_o.phase == PhaseCodeLock,
    "lock_reference outside lock phase")
  `SSS_ASSERT_NOW(a_cmd_phase,
    out_valid_o && (out_data_o.send_enable || out_data_o.send_speed_mode),
    out_data_o.phase == PhaseCodeEnable || out_data_o.phase == PhaseCodeSpeed,
    "command sent outside a command phase")

endmodule

bind stabilizer_startup_sequencer sss_checker u_sss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
